FILE: src/mpc_pkg.sv
// shared types and constants for the media playback controller
// no dependencies; imported by mpc_event and media_playback_controller_unit
package mpc_pkg;

  localparam logic [4:0] VOL_MAX        = 5'd30;
  localparam logic [4:0] VOL_INIT       = 5'd10;
  localparam logic [9:0] CMD_AGE_MAX    = 10'd1023;
  localparam logic [7:0] SETTLE_AGE_MAX = 8'd255;

  typedef enum logic [2:0] {
    MODE_TICK     = 3'd0,
    MODE_PLAY     = 3'd1,
    MODE_PREV     = 3'd2,
    MODE_NEXT     = 3'd3,
    MODE_SOURCE   = 3'd4,
    MODE_VOL_UP   = 3'd5,
    MODE_VOL_DOWN = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_PLAY    = 3'd1,
    CMD_PAUSE   = 3'd2,
    CMD_NEXT    = 3'd3,
    CMD_PREV    = 3'd4,
    CMD_SET_VOL = 3'd5
  } command_t;

  typedef enum logic [1:0] {
    REG_TRACK_COUNT = 2'd0,
    REG_SETTLE      = 2'd1,
    REG_BLANK       = 2'd2,
    REG_ACTIVE_LOW  = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [7:0] track_count;
    logic [7:0] busy_settle_ms;
    logic [9:0] command_blank_ms;
    logic       busy_active_low;
  } cfg_t;

  typedef struct packed {
    logic       play_flag;
    logic [4:0] volume_level;
    logic [7:0] track_number;
    logic       source_select;
    logic       busy_sample;
    logic       busy_stable;
    logic [9:0] command_age;
    logic [7:0] settle_age;
  } ctrl_state_t;

endpackage

FILE: src/mpc_event.sv
// next-state and command logic for one event
// depends on mpc_pkg
module mpc_event
  import mpc_pkg::*;
(
  input  ctrl_state_t cur,
  input  cfg_t        cfg,
  input  logic [2:0]  mode,
  input  logic        busy_pin,
  output ctrl_state_t nxt,
  output command_t    command
);

  logic       card;
  logic [7:0] eff_total;
  logic [7:0] track_up;
  logic [7:0] track_down;
  logic [9:0] cage_inc;
  logic [7:0] sage_inc;
  logic       pin_idle;

  assign card       = ~cur.source_select;
  assign eff_total  = (cfg.track_count == 8'd0) ? 8'd1 : cfg.track_count;
  assign track_up   = (cur.track_number < eff_total) ? cur.track_number + 8'd1 : 8'd1;
  assign track_down = (cur.track_number > 8'd1) ? cur.track_number - 8'd1 : eff_total;
  assign cage_inc   = (cur.command_age < CMD_AGE_MAX) ? cur.command_age + 10'd1
                                                       : cur.command_age;
  assign sage_inc   = (cur.settle_age < SETTLE_AGE_MAX) ? cur.settle_age + 8'd1
                                                         : cur.settle_age;
  assign pin_idle   = cfg.busy_active_low ? busy_pin : ~busy_pin;

  always_comb begin
    nxt     = cur;
    command = CMD_NONE;
    case (mode_t'(mode))
      MODE_TICK: begin
        nxt.command_age = cage_inc;
        nxt.settle_age  = sage_inc;
        // busy is only watched on the card source once blanking has run out
        if (card && cage_inc >= cfg.command_blank_ms) begin
          if (pin_idle != cur.busy_sample) begin
            nxt.busy_sample = pin_idle;
            nxt.settle_age  = 8'd0;
          end else if (sage_inc >= cfg.busy_settle_ms &&
                       cur.busy_stable != cur.busy_sample) begin
            nxt.busy_stable = cur.busy_sample;
            // track finished: busy-to-idle while playing
            if (!cur.busy_stable && cur.play_flag) begin
              nxt.track_number = track_up;
              nxt.command_age  = 10'd0;
              command          = CMD_NEXT;
            end
          end
        end
      end
      MODE_PLAY: begin
        if (card) begin
          command         = cur.play_flag ? CMD_PAUSE : CMD_PLAY;
          nxt.play_flag   = ~cur.play_flag;
          nxt.command_age = 10'd0;
        end
      end
      MODE_PREV: begin
        if (card) begin
          nxt.track_number = track_down;
          nxt.play_flag    = 1'b1;
          nxt.command_age  = 10'd0;
          command          = CMD_PREV;
        end
      end
      MODE_NEXT: begin
        if (card) begin
          nxt.track_number = track_up;
          nxt.play_flag    = 1'b1;
          nxt.command_age  = 10'd0;
          command          = CMD_NEXT;
        end
      end
      MODE_SOURCE: begin
        if (card) begin
          if (cur.play_flag) begin
            nxt.play_flag   = 1'b0;
            nxt.command_age = 10'd0;
            command         = CMD_PAUSE;
          end
          nxt.source_select = 1'b1;
        end else begin
          nxt.source_select = 1'b0;
        end
      end
      MODE_VOL_UP: begin
        if (card && cur.volume_level < VOL_MAX) begin
          nxt.volume_level = cur.volume_level + 5'd1;
          command          = CMD_SET_VOL;
        end
      end
      MODE_VOL_DOWN: begin
        if (card && cur.volume_level > 5'd0) begin
          nxt.volume_level = cur.volume_level - 5'd1;
          command          = CMD_SET_VOL;
        end
      end
      default: begin
        nxt     = cur;
        command = CMD_NONE;
      end
    endcase
  end

endmodule

FILE: src/media_playback_controller_unit.sv
// top level of the media playback controller: state, config and stream ports
// depends on mpc_pkg and mpc_event
//
// Takes one event beat per clock while ready (1 ms tick with the raw busy pin,
// or a user command) and returns exactly one result beat per event, carrying
// the player command and the state after the event. Each event is resolved in
// the cycle it is accepted: the controller state registers and the result
// register update together; the rate is one event per cycle while results are
// taken. The result register lets the next event in while a result is still
// waiting, as long as the result is taken in the same cycle. Configuration
// writes take effect on the next event and should only be made while idle.
module media_playback_controller_unit
  import mpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  // event stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] busy_pin, [7:1] zero
  input  logic [2:0]  s_tuser,   // [2:0] mode
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [4:0] volume, [12:5] track, [13] playing,
                                 // [14] source, [15] source (repeated)
  output logic [2:0]  m_tuser    // [2:0] command
);

  cfg_t        cfg;
  ctrl_state_t state;
  ctrl_state_t state_next;
  command_t    command_next;
  logic        accept;

  logic [2:0]  command;
  logic [4:0]  volume;
  logic [7:0]  track;
  logic        playing;
  logic        source;

  assign s_tready = ~m_tvalid | m_tready;
  assign accept   = s_tvalid & s_tready;

  mpc_event u_event (
    .cur      (state),
    .cfg      (cfg),
    .mode     (s_tuser),
    .busy_pin (s_tdata[0]),
    .nxt      (state_next),
    .command  (command_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.track_count      <= 8'd5;
      cfg.busy_settle_ms   <= 8'd20;
      cfg.command_blank_ms <= 10'd500;
      cfg.busy_active_low  <= 1'b1;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_TRACK_COUNT: cfg.track_count      <= cfg_data[7:0];
        REG_SETTLE:      cfg.busy_settle_ms   <= cfg_data[7:0];
        REG_BLANK:       cfg.command_blank_ms <= cfg_data;
        REG_ACTIVE_LOW:  cfg.busy_active_low  <= cfg_data[0];
        default:         cfg <= cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.play_flag     <= 1'b0;
      state.volume_level  <= VOL_INIT;
      state.track_number  <= 8'd1;
      state.source_select <= 1'b0;
      state.busy_sample   <= 1'b1;
      state.busy_stable   <= 1'b1;
      state.command_age   <= 10'd0;
      state.settle_age    <= 8'd0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (accept) begin
      command <= command_next;
      volume  <= state_next.volume_level;
      track   <= state_next.track_number;
      playing <= state_next.play_flag;
      source  <= state_next.source_select;
    end
  end

  assign m_tuser = command;
  assign m_tdata = {source, source, playing, track, volume};

endmodule
